>>> hdl/ffha_pkg.sv
// Package for the first-fit heap allocator.
// Holds field widths, status codes, the command word, operation and state types.
`default_nettype none
package ffha_pkg;

    localparam int HEAP_BYTES_DEF   = 2048;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAX_BLOCKS_DEF   = 32;

    localparam int CMD_W   = 1;
    localparam int REQ_W   = 12;
    localparam int ADDR_W  = 11;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 6;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FIT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_USCAN,
        S_FRD,
        S_FCHK,
        S_DEC,
        S_SRD,
        S_SWR,
        S_INS,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> hdl/ffha_if.sv
// Valid/ready channel interfaces for the command and response words.
// Depends on ffha_pkg for the field widths.
`default_nettype none
interface ffha_in_if;
    logic                       valid;
    logic                       ready;
    logic [ffha_pkg::CMD_W-1:0]  command;
    logic [ffha_pkg::REQ_W-1:0]  request_bytes;
    logic [ffha_pkg::ADDR_W-1:0] block_address;
    modport source (output valid, command, request_bytes, block_address, input ready);
    modport sink   (input valid, command, request_bytes, block_address, output ready);
endinterface

interface ffha_out_if;
    logic                        valid;
    logic                        ready;
    logic [ffha_pkg::STAT_W-1:0]  status;
    logic [ffha_pkg::ADDR_W-1:0]  granted_address;
    logic [ffha_pkg::COUNT_W-1:0] free_segment_count;
    modport source (output valid, status, granted_address, free_segment_count, input ready);
    modport sink   (input valid, status, granted_address, free_segment_count, output ready);
endinterface
`default_nettype wire

>>> hdl/ffha_front.sv
// Front end: accepts command words, decodes the operation, and queues them.
// Depends on ffha_pkg and ffha_if.
`default_nettype none
module ffha_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ffha_in_if.sink             i_cmd,
    output ffha_pkg::t_cmd      o_q_data,
    output logic                o_q_valid,
    input  wire logic           i_q_ready
);
    import ffha_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_in;

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign w_pop       = o_q_valid && i_q_ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_data    = r_slot[r_rp];

    always_comb begin
        w_in.op   = t_op'(i_cmd.command);
        w_in.req  = i_cmd.request_bytes;
        w_in.addr = i_cmd.block_address;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_slot[r_wp] <= w_in;
    end
endmodule
`default_nettype wire

>>> hdl/ffha_back.sv
// Back end: runs allocate and free over the allocation and free segment tables.
// Depends on ffha_pkg and ffha_if; holds the free segment memory.
`default_nettype none
module ffha_back #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ffha_pkg::t_cmd i_q_data,
    input  wire logic           i_q_valid,
    output logic                o_q_ready,
    ffha_out_if.source          o_rsp
);
    import ffha_pkg::*;

    localparam int DW  = $clog2(HEAP_BYTES + 4096) + 1;
    localparam int FS  = MAX_BLOCKS + 1;
    localparam int UIW = $clog2(MAX_BLOCKS);
    localparam int FIW = $clog2(FS);
    localparam int CW  = $clog2(FS + 1);
    localparam logic [DW-1:0] HDR  = DW'(HEADER_BYTES);
    localparam logic [DW-1:0] INIT = DW'(HEAP_BYTES - HEADER_BYTES);

    typedef struct packed {
        logic [DW-1:0] start;
        logic [DW-1:0] bytes;
    } t_ent;

    t_state r_state, n_state;
    t_op    r_op;
    logic [DW-1:0] r_req, r_addr, r_seg, r_sz, r_grant;
    logic [UIW-1:0] r_u;
    logic [CW-1:0]  r_k, r_pos, r_total;
    logic r_up, r_hcur;
    t_ent r_prev, r_cur, r_rd;
    logic [STAT_W-1:0] r_status;

    t_ent r_fmem [FS];
    logic [MAX_BLOCKS-1:0] r_uvalid;
    logic [DW-1:0] r_ustart [MAX_BLOCKS];
    logic [DW-1:0] r_ubytes [MAX_BLOCKS];

    logic r_ovalid;
    logic [STAT_W-1:0] r_ostat;
    logic [ADDR_W-1:0] r_ogrant;
    logic [COUNT_W-1:0] r_ocount;

    // decision terms
    logic w_ufree, w_umatch, w_ulast, w_kend, w_fit, w_split, w_left, w_right;
    logic w_room, w_out_free, w_kpos;
    logic [DW-1:0] w_diff;
    logic [CW+COUNT_W-1:0] w_cnt_ext;

    // datapath controls
    logic w_we;
    logic [FIW-1:0] w_wa;
    t_ent w_wd;
    logic w_uset, w_uclr;
    logic [DW-1:0] w_uwstart, w_uwbytes;

    assign w_ufree  = !r_uvalid[r_u];
    assign w_umatch = r_uvalid[r_u] && (r_ustart[r_u] == r_addr);
    assign w_ulast  = (r_u == UIW'(MAX_BLOCKS - 1));
    assign w_kend   = (r_k >= r_total);
    assign w_fit    = (r_rd.bytes >= r_req);
    assign w_diff   = r_rd.bytes - r_req;
    assign w_split  = (w_diff > HDR);
    assign w_left   = (r_pos != '0) && (r_prev.start + HDR + r_prev.bytes == r_seg);
    assign w_right  = r_hcur && (r_seg + HDR + r_sz == r_cur.start);
    assign w_room   = (r_total < CW'(FS));
    assign w_kpos   = (r_k == r_pos);
    assign w_out_free = !r_ovalid || o_rsp.ready;
    assign o_q_ready = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_q_valid) n_state = S_USCAN;
            S_USCAN: begin
                if (r_op == OP_ALLOC) begin
                    if (w_ufree) n_state = S_FRD;
                    else if (w_ulast) n_state = S_DONE;
                end else begin
                    if (w_umatch) n_state = S_FRD;
                    else if (w_ulast) n_state = S_DONE;
                end
            end
            S_FRD: begin
                if (!w_kend) n_state = S_FCHK;
                else if (r_op == OP_ALLOC) n_state = S_DONE;
                else n_state = S_DEC;
            end
            S_FCHK: begin
                if (r_op == OP_ALLOC) begin
                    if (!w_fit) n_state = S_FRD;
                    else if (w_split) n_state = S_DONE;
                    else n_state = S_SRD;
                end else begin
                    n_state = (r_rd.start > r_seg) ? S_DEC : S_FRD;
                end
            end
            S_DEC: begin
                if (w_left && w_right) n_state = S_SRD;
                else if (w_left || w_right || !w_room) n_state = S_DONE;
                else if (r_total > r_pos) n_state = S_SRD;
                else n_state = S_INS;
            end
            S_SRD:   n_state = (!r_up && w_kend) ? S_DONE : S_SWR;
            S_SWR:   n_state = (!r_up) ? S_SRD : (w_kpos ? S_INS : S_SRD);
            S_INS:   n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and table controls
    always_comb begin
        w_we = 1'b0;
        w_wa = r_k[FIW-1:0];
        w_wd = r_rd;
        w_uset = 1'b0;
        w_uclr = 1'b0;
        w_uwstart = r_rd.start + HDR;
        w_uwbytes = r_req;
        unique case (r_state)
            S_FCHK: begin
                if (r_op == OP_ALLOC && w_fit) begin
                    w_uset = 1'b1;
                    if (w_split) begin
                        w_we = 1'b1;
                        w_wd.start = r_rd.start + HDR + r_req;
                        w_wd.bytes = w_diff - HDR;
                    end else begin
                        w_uwbytes = r_rd.bytes;
                    end
                end
            end
            S_USCAN: w_uclr = (r_op == OP_FREE) && w_umatch;
            S_DEC: begin
                if (w_left) begin
                    w_we = 1'b1;
                    w_wa = FIW'(r_pos - CW'(1));
                    w_wd.start = r_prev.start;
                    w_wd.bytes = w_right ? r_prev.bytes + HDR + r_sz + HDR + r_cur.bytes
                                         : r_prev.bytes + HDR + r_sz;
                end else if (w_right) begin
                    w_we = 1'b1;
                    w_wa = r_pos[FIW-1:0];
                    w_wd.start = r_seg;
                    w_wd.bytes = r_sz + HDR + r_cur.bytes;
                end
            end
            S_SWR: begin
                w_we = 1'b1;
                w_wa = r_up ? FIW'(r_k + CW'(1)) : FIW'(r_k - CW'(1));
            end
            S_INS: begin
                w_we = 1'b1;
                w_wa = r_pos[FIW-1:0];
                w_wd.start = r_seg;
                w_wd.bytes = r_sz;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= CW'(1);
            r_uvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_uset) r_uvalid[r_u] <= 1'b1;
            if (w_uclr) r_uvalid[r_u] <= 1'b0;
            if (r_state == S_DONE && w_out_free) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
            if ((r_state == S_SRD && !r_up && w_kend)) r_total <= r_total - CW'(1);
            if (r_state == S_INS) r_total <= r_total + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fmem[0] <= '{start: '0, bytes: INIT};
        else if (w_we) r_fmem[w_wa] <= w_wd;
        r_rd <= r_fmem[r_k[FIW-1:0]];
        if (w_uset) begin
            r_ustart[r_u] <= w_uwstart;
            r_ubytes[r_u] <= w_uwbytes;
        end
    end

    assign w_cnt_ext = {{COUNT_W{1'b0}}, r_total};

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op     <= i_q_data.op;
                r_req    <= {{(DW-REQ_W){1'b0}}, i_q_data.req};
                r_addr   <= {{(DW-ADDR_W){1'b0}}, i_q_data.addr};
                r_u      <= '0;
                r_k      <= '0;
                r_grant  <= '0;
                r_status <= ST_OK;
                r_hcur   <= 1'b0;
            end
            S_USCAN: begin
                if (r_op == OP_ALLOC) begin
                    if (!w_ufree && w_ulast) r_status <= ST_FULL;
                    else if (!w_ufree) r_u <= r_u + UIW'(1);
                end else if (w_umatch) begin
                    r_seg <= r_ustart[r_u] - HDR;
                    r_sz  <= r_ubytes[r_u];
                end else if (w_ulast) begin
                    r_status <= ST_UNKNOWN;
                end else begin
                    r_u <= r_u + UIW'(1);
                end
            end
            S_FRD: begin
                if (w_kend && r_op == OP_ALLOC) r_status <= ST_NO_FIT;
                if (w_kend) r_pos <= r_k;
            end
            S_FCHK: begin
                if (r_op == OP_ALLOC) begin
                    if (!w_fit) r_k <= r_k + CW'(1);
                    else begin
                        r_grant <= r_rd.start + HDR;
                        r_k     <= r_k + CW'(1);
                        r_up    <= 1'b0;
                    end
                end else if (r_rd.start > r_seg) begin
                    r_hcur <= 1'b1;
                    r_cur  <= r_rd;
                    r_pos  <= r_k;
                end else begin
                    r_prev <= r_rd;
                    r_k    <= r_k + CW'(1);
                end
            end
            S_DEC: begin
                if (w_left && w_right) begin
                    r_k  <= r_pos + CW'(1);
                    r_up <= 1'b0;
                end else begin
                    r_k  <= r_total - CW'(1);
                    r_up <= 1'b1;
                end
            end
            S_SWR: r_k <= r_up ? r_k - CW'(1) : r_k + CW'(1);
            S_DONE: begin
                if (w_out_free) begin
                    r_ostat  <= r_status;
                    r_ogrant <= r_grant[ADDR_W-1:0];
                    r_ocount <= w_cnt_ext[COUNT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid              = r_ovalid;
    assign o_rsp.status             = r_ostat;
    assign o_rsp.granted_address    = r_ogrant;
    assign o_rsp.free_segment_count = r_ocount;
endmodule
`default_nettype wire

>>> hdl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: front queue plus table engine.
// Depends on ffha_pkg, ffha_if, ffha_front and ffha_back.
//
//   channel  | dir | word
//   i_cmd    | in  | command, request_bytes, block_address
//   o_rsp    | out | status, granted_address, free_segment_count
//
// One word is worked at a time. An allocate scans the allocation table one
// entry a cycle, then the free segment memory, reading each entry in S_FRD
// and checking it in S_FCHK; a drop shifts each later entry down through
// S_SRD and S_SWR. A free scans the same way and may shift entries up on
// insertion. Reset is synchronous; a two-word queue takes commands while
// the engine is busy, and a stalled response holds the engine in its last
// step.
`default_nettype none
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ffha_in_if.sink   i_cmd,
    ffha_out_if.source o_rsp
);
    import ffha_pkg::*;

    t_cmd w_q_data;
    logic w_q_valid;
    logic w_q_ready;

    ffha_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_data  (w_q_data),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready)
    );

    ffha_back #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (w_q_data),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .o_rsp     (o_rsp)
    );

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status != ST_OK) |-> (o_rsp.granted_address == '0))
        else $error("granted address set on a failed step");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (32'(o_rsp.free_segment_count) <= 32'(MAX_BLOCKS + 1)))
        else $error("free segment count beyond table depth");

    a_grant_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_OK) && (o_rsp.granted_address != '0)
        |-> (32'(o_rsp.granted_address) >= 32'(HEADER_BYTES)))
        else $error("granted address inside a header");
endmodule
`default_nettype wire
